FILE: rtl/planar_go_to_goal_velocity_macros.svh
// ----------------------------------------------------------------------------
// planar_go_to_goal_velocity_macros
// Assertion macros shared by the go-to-goal controller RTL.
// ----------------------------------------------------------------------------
`ifndef PLANAR_GO_TO_GOAL_VELOCITY_MACROS_SVH
`define PLANAR_GO_TO_GOAL_VELOCITY_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define PGTGV_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("pgtgv: check failed");

// ante implies cons in the same cycle
`define PGTGV_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgtgv: implication failed");

// ante implies cons in the next cycle
`define PGTGV_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgtgv: sequence failed");

`else

`define PGTGV_ASSERT(lbl, clk, rst_n, expr)
`define PGTGV_IMPLY(lbl, clk, rst_n, ante, cons)
`define PGTGV_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/pgtgv_pkg.sv
// ----------------------------------------------------------------------------
// pgtgv_pkg
// Types, constants and helpers of the planar go-to-goal controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgtgv_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int YAW_W     = 19;
  localparam int DIFF_W    = POS_W + 1;
  localparam int VEL_W     = 32;
  localparam int LIM_W     = 31;
  localparam int TOL_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // rotator datapath
  localparam int CDC_W      = 36;
  localparam int ANG_W      = 21;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int Q30_SH     = 30 - FRAC_BITS;

  // gain compensation, Q24, split multiply
  localparam int GAIN_SH   = 24;
  localparam int GAIN_W    = 25;
  localparam int MUL_LO_W  = CDC_W / 2;
  localparam int MUL_OP_W  = MUL_LO_W + 1;
  localparam int PP_W      = MUL_OP_W + GAIN_W;
  localparam int ACC_W     = CDC_W + GAIN_W;
  localparam int SAT_W     = ACC_W - GAIN_SH;
  localparam int MUL_PARTS = 4;
  localparam int MCNT_W    = 3;

  localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 25'sd10188014;
  localparam logic signed [ACC_W-1:0]  GAIN_RND = ACC_W'(64'd1 << (GAIN_SH - 1));

  localparam logic [32:0] Q30_RND = 33'(64'd1 << (Q30_SH - 1));
  localparam logic [32:0] PI_RAW  = 33'd3373259426 + Q30_RND;
  localparam logic signed [ANG_W-1:0] PI_FIX      = ANG_W'(PI_RAW >> Q30_SH);
  localparam logic signed [ANG_W-1:0] TWO_PI_FIX  = PI_FIX <<< 1;
  localparam logic signed [ANG_W-1:0] HALF_PI_FIX = PI_FIX >>> 1;

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // config reset values
  localparam logic [LIM_W-1:0] X_LIM_RST    = 31'd13107;
  localparam logic [LIM_W-1:0] Y_LIM_RST    = 31'd13107;
  localparam logic [LIM_W-1:0] TURN_LIM_RST = 31'd32768;
  localparam logic [TOL_W-1:0] POS_TOL_RST  = 16'd328;
  localparam logic [TOL_W-1:0] HEAD_TOL_RST = 16'd3277;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    REQ_ODOM = 2'd0,
    REQ_GOAL = 2'd1,
    REQ_TICK = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LIMIT    = 3'd0,
    CFG_Y_LIMIT    = 3'd1,
    CFG_TURN_LIMIT = 3'd2,
    CFG_POS_TOL    = 3'd3,
    CFG_HEAD_TOL   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    JOB_TURN   = 2'd0,
    JOB_ARRIVE = 2'd1,
    JOB_MOVE   = 2'd2
  } job_e;

  typedef enum logic [2:0] {
    B_IDLE = 3'd0,
    B_LOAD = 3'd1,
    B_ROT  = 3'd2,
    B_MUL  = 3'd3,
    B_DONE = 3'd4
  } back_state_e;

  typedef struct packed {
    logic [LIM_W-1:0] x_lim;
    logic [LIM_W-1:0] y_lim;
    logic [LIM_W-1:0] turn_lim;
    logic [TOL_W-1:0] pos_tol;
    logic [TOL_W-1:0] head_tol;
  } cfg_t;

  typedef struct packed {
    job_e                     kind;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [YAW_W-1:0]  yaw;
    logic signed [VEL_W-1:0]  turn;
  } job_t;

  function automatic logic signed [ANG_W-1:0] atan_fix(input logic [ATAN_IDX_W-1:0] i);
    logic [32:0] r;
    r = {1'b0, ATAN_Q30[i]} + Q30_RND;
    return ANG_W'(r >> Q30_SH);
  endfunction

  function automatic logic signed [VEL_W-1:0] clamp_vel(input logic signed [SAT_W-1:0] v,
                                                        input logic [LIM_W-1:0] lim);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    logic signed [SAT_W-1:0] r;
    hi = signed'({{(SAT_W - LIM_W){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[VEL_W-1:0];
  endfunction

endpackage

FILE: rtl/pgtgv_front.sv
// ----------------------------------------------------------------------------
// pgtgv_front
// Takes pose, goal and tick requests, keeps the pose state and classifies ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgtgv_front
  import pgtgv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [YAW_W-1:0] heading_i,
  output logic                    push_o,
  output job_t                    job_o,
  input  logic                    q_full_i
);

  logic signed [POS_W-1:0]  cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
  logic signed [YAW_W-1:0]  cur_yaw_q, tgt_yaw_q, yaw_q;
  logic                     moving_q, pend_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic signed [ANG_W-1:0]  dz_q;

  logic                     in_acc;
  logic signed [ANG_W-1:0]  htol;
  logic signed [DIFF_W-1:0] ptol;
  logic                     head_ok, pos_ok;

  assign in_acc     = in_valid_i && !in_stall_o;
  // pend_q marks a tick being classified until its job is pushed; it also holds off pose updates
  assign in_stall_o = pend_q;
  assign push_o     = pend_q && !q_full_i;

  always_comb begin
    htol    = signed'({{(ANG_W - TOL_W){1'b0}}, cfg_i.head_tol});
    ptol    = signed'({{(DIFF_W - TOL_W){1'b0}}, cfg_i.pos_tol});
    head_ok = (dz_q > -htol) && (dz_q < htol);
    pos_ok  = (dx_q > -ptol) && (dx_q < ptol) && (dy_q > -ptol) && (dy_q < ptol);

    job_o.dx   = dx_q;
    job_o.dy   = dy_q;
    job_o.yaw  = yaw_q;
    job_o.turn = clamp_vel(SAT_W'(dz_q), cfg_i.turn_lim);
    if (!head_ok) begin
      job_o.kind = JOB_TURN;
    end else if (pos_ok) begin
      job_o.kind = JOB_ARRIVE;
    end else begin
      job_o.kind = JOB_MOVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      cur_yaw_q <= '0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      tgt_yaw_q <= '0;
      moving_q  <= 1'b0;
      pend_q    <= 1'b0;
      dx_q      <= '0;
      dy_q      <= '0;
      dz_q      <= '0;
      yaw_q     <= '0;
    end else begin
      if (in_acc) begin
        unique case (req_e'(req_type_i))
          REQ_ODOM: begin
            cur_x_q   <= pos_x_i;
            cur_y_q   <= pos_y_i;
            cur_yaw_q <= heading_i;
          end
          REQ_GOAL: begin
            tgt_x_q   <= pos_x_i;
            tgt_y_q   <= pos_y_i;
            tgt_yaw_q <= heading_i;
            moving_q  <= 1'b1;
          end
          REQ_TICK: begin
            if (moving_q) begin
              pend_q <= 1'b1;
              dx_q   <= DIFF_W'(tgt_x_q) - DIFF_W'(cur_x_q);
              dy_q   <= DIFF_W'(tgt_y_q) - DIFF_W'(cur_y_q);
              dz_q   <= ANG_W'(tgt_yaw_q) - ANG_W'(cur_yaw_q);
              yaw_q  <= cur_yaw_q;
            end
          end
          default: ;
        endcase
      end
      if (push_o) begin
        pend_q <= 1'b0;
        if (job_o.kind == JOB_ARRIVE) begin
          moving_q <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/pgtgv_queue.sv
// ----------------------------------------------------------------------------
// pgtgv_queue
// Short job queue between the classifier and the velocity engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "planar_go_to_goal_velocity_macros.svh"

module pgtgv_queue
  import pgtgv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `PGTGV_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o))
  `PGTGV_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && !valid_o))
  `PGTGV_NEXT(a_push_visible, clk_i, rst_ni, push_i && !pop_i, valid_o)

endmodule

FILE: rtl/pgtgv_back.sv
// ----------------------------------------------------------------------------
// pgtgv_back
// Velocity engine: CORDIC frame rotation, gain scaling, clamp, result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "planar_go_to_goal_velocity_macros.svh"

module pgtgv_back
  import pgtgv_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    q_valid_i,
  input  job_t                    q_job_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VEL_W-1:0] vel_forward_o,
  output logic signed [VEL_W-1:0] vel_sideways_o,
  output logic signed [VEL_W-1:0] vel_turn_o,
  output logic                    arrived_o
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [MCNT_W-1:0] MCNT_LAST = MCNT_W'(MUL_PARTS);

  back_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [MCNT_W-1:0] mcnt_q, mprev;

  logic signed [CDC_W-1:0] x_q, y_q, x_rot, y_rot, xs, ys;
  logic signed [ANG_W-1:0] z_q, z_rot, at, a_neg, a_wrap, z_fold;
  logic                    flip;

  logic signed [MUL_OP_W-1:0] mop;
  logic signed [PP_W-1:0]     pp_q, pp_d;
  logic signed [ACC_W-1:0]    acc_x_q, acc_y_q, acc_add;

  logic                    out_valid_q, arr_q, arr_d;
  logic signed [VEL_W-1:0] vf_q, vs_q, vt_q, vf_d, vs_d, vt_d;

  logic out_free, out_ld, capture;

  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    out_ld  = 1'b0;
    capture = 1'b0;
    vf_d    = '0;
    vs_d    = '0;
    vt_d    = '0;
    arr_d   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        // turn and arrive requests go straight to the result register
        vt_d  = (q_job_i.kind == JOB_TURN) ? q_job_i.turn : '0;
        arr_d = (q_job_i.kind == JOB_ARRIVE);
        if (q_valid_i) begin
          if (q_job_i.kind == JOB_MOVE) begin
            q_pop_o = 1'b1;
            capture = 1'b1;
            state_d = B_LOAD;
          end else if (out_free) begin
            q_pop_o = 1'b1;
            out_ld  = 1'b1;
          end
        end
      end
      B_LOAD: state_d = B_ROT;
      B_ROT: begin
        if (step_q == STEP_LAST) begin
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        if (mcnt_q == MCNT_LAST) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        vf_d = clamp_vel(signed'(acc_x_q[ACC_W-1:GAIN_SH]), cfg_i.x_lim);
        vs_d = clamp_vel(signed'(acc_y_q[ACC_W-1:GAIN_SH]), cfg_i.y_lim);
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  // rotation angle is -yaw; |yaw| < 2*pi so one wrap step suffices
  always_comb begin
    a_neg = -z_q;
    if (a_neg >= PI_FIX) begin
      a_wrap = a_neg - TWO_PI_FIX;
    end else if (a_neg < -PI_FIX) begin
      a_wrap = a_neg + TWO_PI_FIX;
    end else begin
      a_wrap = a_neg;
    end
    flip = 1'b1;
    if (a_wrap > HALF_PI_FIX) begin
      z_fold = a_wrap - PI_FIX;
    end else if (a_wrap < -HALF_PI_FIX) begin
      z_fold = a_wrap + PI_FIX;
    end else begin
      z_fold = a_wrap;
      flip   = 1'b0;
    end
  end

  always_comb begin
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    at = atan_fix(ATAN_IDX_W'(step_q));
    if (z_q >= 0) begin
      x_rot = x_q - ys;
      y_rot = y_q + xs;
      z_rot = z_q - at;
    end else begin
      x_rot = x_q + ys;
      y_rot = y_q - xs;
      z_rot = z_q + at;
    end
  end

  // gain multiply in four 19x25 partial products: x lo, x hi, y lo, y hi
  always_comb begin
    case (mcnt_q[1:0])
      2'd0:    mop = signed'({1'b0, x_q[MUL_LO_W-1:0]});
      2'd1:    mop = MUL_OP_W'(signed'(x_q[CDC_W-1:MUL_LO_W]));
      2'd2:    mop = signed'({1'b0, y_q[MUL_LO_W-1:0]});
      default: mop = MUL_OP_W'(signed'(y_q[CDC_W-1:MUL_LO_W]));
    endcase
    pp_d    = PP_W'(mop) * PP_W'(GAIN_Q24);
    mprev   = mcnt_q - 1'b1;
    acc_add = mprev[0] ? (ACC_W'(pp_q) <<< MUL_LO_W) : ACC_W'(pp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      mcnt_q <= '0;
    end else begin
      if (state_q == B_LOAD) begin
        step_q <= '0;
        mcnt_q <= '0;
      end
      if (state_q == B_ROT) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == B_MUL) begin
        mcnt_q <= mcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      x_q <= CDC_W'(q_job_i.dx);
      y_q <= CDC_W'(q_job_i.dy);
      z_q <= ANG_W'(q_job_i.yaw);
    end
    if (state_q == B_LOAD) begin
      x_q     <= flip ? -x_q : x_q;
      y_q     <= flip ? -y_q : y_q;
      z_q     <= z_fold;
      acc_x_q <= GAIN_RND;
      acc_y_q <= GAIN_RND;
    end
    if (state_q == B_ROT) begin
      x_q <= x_rot;
      y_q <= y_rot;
      z_q <= z_rot;
    end
    if (state_q == B_MUL) begin
      if (mcnt_q != MCNT_LAST) begin
        pp_q <= pp_d;
      end
      if (mcnt_q != '0) begin
        if (mprev[1]) begin
          acc_y_q <= acc_y_q + acc_add;
        end else begin
          acc_x_q <= acc_x_q + acc_add;
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      vf_q  <= vf_d;
      vs_q  <= vs_d;
      vt_q  <= vt_d;
      arr_q <= arr_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vel_forward_o  = vf_q;
  assign vel_sideways_o = vs_q;
  assign vel_turn_o     = vt_q;
  assign arrived_o      = arr_q;

  `PGTGV_IMPLY(a_arrive_still, clk_i, rst_ni, out_valid_o && arrived_o,
               vel_forward_o == '0 && vel_sideways_o == '0 && vel_turn_o == '0)
  `PGTGV_IMPLY(a_fwd_bound, clk_i, rst_ni, out_valid_o,
               vel_forward_o <= signed'({1'b0, cfg_i.x_lim}) &&
               vel_forward_o >= -signed'({1'b0, cfg_i.x_lim}))
  `PGTGV_NEXT(a_move_starts, clk_i, rst_ni, q_pop_o && q_job_i.kind == JOB_MOVE,
              state_q == B_LOAD)

endmodule

FILE: rtl/planar_go_to_goal_velocity.sv
// ----------------------------------------------------------------------------
// planar_go_to_goal_velocity
// Go-to-goal velocity controller for a planar base: pose and goal requests
// in, one velocity command per control tick while a goal is active.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i/in_stall_o  | req_type_i pos_x_i pos_y_i heading_i
//  out     | out_valid_o/out_stall_i| vel_forward_o vel_sideways_o vel_turn_o
//          |                        | arrived_o
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
//  Pose and goal requests update the state registers directly; a tick holds the
//  input while it is classified, until its job is pushed into a short queue.
//  Turn and arrival results pass from the queue straight into the result
//  register. A translation passes the load, rotate, multiply and done states,
//  with the one-step-per-cycle CORDIC rotator and the four-part gain multiply.
//  Reset clears pose state and restores config defaults; no clearing pass.
//  Output stall holds the result register; input stalls only while a tick is
//  being classified, which a full queue prolongs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module planar_go_to_goal_velocity
  import pgtgv_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic signed [POS_W-1:0]     pos_x_i,
  input  logic signed [POS_W-1:0]     pos_y_i,
  input  logic signed [YAW_W-1:0]     heading_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [VEL_W-1:0]     vel_forward_o,
  output logic signed [VEL_W-1:0]     vel_sideways_o,
  output logic signed [VEL_W-1:0]     vel_turn_o,
  output logic                        arrived_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i
);

  cfg_t cfg_q;
  logic push, q_full, q_valid, q_pop;
  job_t push_job, q_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_lim    <= X_LIM_RST;
      cfg_q.y_lim    <= Y_LIM_RST;
      cfg_q.turn_lim <= TURN_LIM_RST;
      cfg_q.pos_tol  <= POS_TOL_RST;
      cfg_q.head_tol <= HEAD_TOL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_X_LIMIT:    cfg_q.x_lim    <= cfg_data_i[LIM_W-1:0];
        CFG_Y_LIMIT:    cfg_q.y_lim    <= cfg_data_i[LIM_W-1:0];
        CFG_TURN_LIMIT: cfg_q.turn_lim <= cfg_data_i[LIM_W-1:0];
        CFG_POS_TOL:    cfg_q.pos_tol  <= cfg_data_i[TOL_W-1:0];
        CFG_HEAD_TOL:   cfg_q.head_tol <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  pgtgv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .heading_i  (heading_i),
    .push_o     (push),
    .job_o      (push_job),
    .q_full_i   (q_full)
  );

  pgtgv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job),
    .pop_i   (q_pop)
  );

  pgtgv_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_job_i        (q_job),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vel_forward_o  (vel_forward_o),
    .vel_sideways_o (vel_sideways_o),
    .vel_turn_o     (vel_turn_o),
    .arrived_o      (arrived_o)
  );

endmodule

FILE: tb/tb_planar_go_to_goal_velocity.sv
// ----------------------------------------------------------------------------
// tb_planar_go_to_goal_velocity
// Self-checking bench for the go-to-goal controller. A directed table covers
// idle ticks, arrival at the tolerance edges, clamped turns, ignored request
// kinds and extreme poses. Random goal/odometry/tick episodes then run across
// eight phases of register settings and idle/stall patterns. Every velocity
// command is checked against the spec value of its directed row or a cycle-free model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_planar_go_to_goal_velocity;
  import pgtgv_pkg::*;

  localparam logic [1:0]           REQ_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE       = 3'd7;
  localparam int                   N_PHASES       = 8;
  localparam int                   PHASE_ITEMS    = 125;
  localparam int                   HOLD_CYCLES    = 150;
  localparam int                   SETTLE_CYCLES  = 40;
  localparam int                   WATCHDOG_LIMIT = 5000;

  // rotator constants
  localparam int     CORDIC_ITERS = 16;
  localparam int     Q30_SHIFT    = 14;
  localparam longint PI_Q30       = 64'd3373259426;
  localparam longint GAIN_COMP    = 64'd10188014;
  localparam longint ATAN_TAB [CORDIC_ITERS] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };

  typedef struct packed {
    logic signed [VEL_W-1:0] fwd;
    logic signed [VEL_W-1:0] side;
    logic signed [VEL_W-1:0] turn;
    logic                    arrived;
  } vel_cmd_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [YAW_W-1:0] yaw;
    logic                    known;
    vel_cmd_t                cmd;
  } stim_row_t;

  localparam logic signed [POS_W-1:0] POS_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN      = 32'sh8000_0000;
  localparam logic signed [YAW_W-1:0] YAW_MAX      = 19'sd205887;
  localparam logic signed [YAW_W-1:0] YAW_MIN      = -19'sd205887;
  localparam logic signed [YAW_W-1:0] YAW_FULL_MAX = 19'sh3FFFF;
  localparam logic signed [YAW_W-1:0] YAW_FULL_MIN = 19'sh40000;
  localparam vel_cmd_t NO_CMD     = '0;
  localparam vel_cmd_t ARRIVE_CMD = '{32'sd0, 32'sd0, 32'sd0, 1'b1};

  // directed requests at reset settings; known commands read straight off the spec
  localparam stim_row_t DIRECTED [28] = '{
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_UNUSED, POS_MAX,   POS_MIN,   YAW_MAX, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_GOAL,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b1, ARRIVE_CMD},
    '{REQ_GOAL,   32'sd0,    32'sd0,    YAW_MAX, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b1,
      '{32'sd0, 32'sd0, 32'sd32768, 1'b0}},
    '{REQ_GOAL,   32'sd0,    32'sd0,    YAW_MIN, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b1,
      '{32'sd0, 32'sd0, -32'sd32768, 1'b0}},
    '{REQ_GOAL,   32'sd327,  -32'sd327, 19'sd3276, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b1, ARRIVE_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_GOAL,   32'sd0,    32'sd0,    19'sd3277, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b1,
      '{32'sd0, 32'sd0, 32'sd3277, 1'b0}},
    '{REQ_GOAL,   32'sd328,  32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_ODOM,   32'sd0,    32'sd0,    -19'sd100, 1'b0, NO_CMD},
    '{REQ_GOAL,   32'sd6553, -32'sd3000, -19'sd100, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_ODOM,   32'sd1000, -32'sd1000, 19'sd131072, 1'b0, NO_CMD},
    '{REQ_GOAL,   -32'sd5000, 32'sd7000, 19'sd131072, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_ODOM,   POS_MIN,   POS_MAX,   YAW_FULL_MIN, 1'b0, NO_CMD},
    '{REQ_GOAL,   POS_MAX,   POS_MIN,   YAW_FULL_MIN, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD},
    '{REQ_ODOM,   POS_MAX,   POS_MIN,   YAW_FULL_MAX, 1'b0, NO_CMD},
    '{REQ_GOAL,   POS_MIN,   POS_MAX,   YAW_FULL_MAX, 1'b0, NO_CMD},
    '{REQ_TICK,   32'sd0,    32'sd0,    19'sd0,  1'b0, NO_CMD}
  };

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              req_type_i     = '0;
  logic signed [POS_W-1:0] pos_x_i        = '0;
  logic signed [POS_W-1:0] pos_y_i        = '0;
  logic signed [YAW_W-1:0] heading_i      = '0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic signed [VEL_W-1:0] vel_forward_o;
  logic signed [VEL_W-1:0] vel_sideways_o;
  logic signed [VEL_W-1:0] vel_turn_o;
  logic                    arrived_o;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i    = '0;
  logic [CFG_DAT_W-1:0]    cfg_data_i     = '0;

  // controller model state
  logic signed [POS_W-1:0] cur_x = '0, cur_y = '0, goal_x = '0, goal_y = '0;
  logic signed [YAW_W-1:0] cur_yaw = '0, goal_yaw = '0;
  logic                    moving = 1'b0;
  longint fwd_lim_q  = 13107;
  longint side_lim_q = 13107;
  longint turn_lim_q = 32768;
  longint pos_tol_q  = 328;
  longint head_tol_q = 3277;

  vel_cmd_t cmd_q [$];

  int  errors = 0;
  int  n_items = 0, n_checked = 0, n_writes = 0;
  int  n_turns = 0, n_moves = 0, n_arrivals = 0;
  int  idle_pct = 0, stall_pct = 0;
  int  hold_left = 0, idle_cycles = 0;
  bit  hold_req = 1'b0;

  planar_go_to_goal_velocity dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .heading_i      (heading_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vel_forward_o  (vel_forward_o),
    .vel_sideways_o (vel_sideways_o),
    .vel_turn_o     (vel_turn_o),
    .arrived_o      (arrived_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic longint q30_fix(input longint v);
    return (v + (64'sd1 <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT;
  endfunction

  function automatic longint mag_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint sat(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // rotate (vx, vy) by ang; angle is folded into +-pi/2 first
  function automatic void cordic_rotate(input longint vx, input longint vy, input longint ang,
                                        output longint rx, output longint ry);
    longint pi_f, z, xs, ys;
    pi_f = q30_fix(PI_Q30);
    z = ang % (2 * pi_f);
    if (z >= pi_f) z -= 2 * pi_f;
    if (z < -pi_f) z += 2 * pi_f;
    if (z > pi_f / 2) begin
      z -= pi_f;
      vx = -vx;
      vy = -vy;
    end else if (z < -(pi_f / 2)) begin
      z += pi_f;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (z >= 0) begin
        vx -= ys;
        vy += xs;
        z -= q30_fix(ATAN_TAB[i]);
      end else begin
        vx += ys;
        vy -= xs;
        z += q30_fix(ATAN_TAB[i]);
      end
    end
    rx = (vx * GAIN_COMP + 64'sd8388608) >>> 24;
    ry = (vy * GAIN_COMP + 64'sd8388608) >>> 24;
  endfunction

  // updates pose state; returns 1 when the request yields a velocity command
  function automatic bit predict_cmd(input logic [1:0] kind, input logic signed [POS_W-1:0] px,
                                     input logic signed [POS_W-1:0] py,
                                     input logic signed [YAW_W-1:0] pyaw,
                                     output vel_cmd_t cmd);
    longint ex, ey, ez, lx, ly;
    cmd = '0;
    case (kind)
      REQ_ODOM: begin
        cur_x = px;
        cur_y = py;
        cur_yaw = pyaw;
        return 1'b0;
      end
      REQ_GOAL: begin
        goal_x = px;
        goal_y = py;
        goal_yaw = pyaw;
        moving = 1'b1;
        return 1'b0;
      end
      REQ_TICK: begin
        if (!moving) return 1'b0;
      end
      default: return 1'b0;
    endcase
    // errors kept wide enough that the 32-bit extremes never wrap
    ex = longint'(goal_x) - longint'(cur_x);
    ey = longint'(goal_y) - longint'(cur_y);
    ez = longint'(goal_yaw) - longint'(cur_yaw);
    if (mag_l(ez) < head_tol_q) begin
      if (mag_l(ex) < pos_tol_q && mag_l(ey) < pos_tol_q) begin
        moving = 1'b0;
        cmd.arrived = 1'b1;
        n_arrivals++;
      end else begin
        cordic_rotate(ex, ey, -longint'(cur_yaw), lx, ly);
        cmd.fwd = 32'(sat(lx, fwd_lim_q));
        cmd.side = 32'(sat(ly, side_lim_q));
        n_moves++;
      end
    end else begin
      cmd.turn = 32'(sat(ez, turn_lim_q));
      n_turns++;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_req(input logic [1:0] kind, input logic signed [POS_W-1:0] px,
                          input logic signed [POS_W-1:0] py,
                          input logic signed [YAW_W-1:0] pyaw,
                          input logic known, input vel_cmd_t known_cmd);
    vel_cmd_t cmd;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      req_type_i <= 2'($urandom);
      pos_x_i <= 32'($urandom);
      pos_y_i <= 32'($urandom);
      heading_i <= 19'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    pos_x_i <= px;
    pos_y_i <= py;
    heading_i <= pyaw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind != REQ_UNUSED) n_items++;
    if (predict_cmd(kind, px, py, pyaw, cmd)) cmd_q.push_back(known ? known_cmd : cmd);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_X_LIMIT:    fwd_lim_q = longint'(data[LIM_W-1:0]);
      CFG_Y_LIMIT:    side_lim_q = longint'(data[LIM_W-1:0]);
      CFG_TURN_LIMIT: turn_lim_q = longint'(data[LIM_W-1:0]);
      CFG_POS_TOL:    pos_tol_q = longint'(data[TOL_W-1:0]);
      CFG_HEAD_TOL:   head_tol_q = longint'(data[TOL_W-1:0]);
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering requests, let every command come back, then let the block settle
  task automatic drain_cmds();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input int sel);
    case (sel)
      1: begin
        for (int r = CFG_X_LIMIT; r <= CFG_HEAD_TOL; r++) write_reg(3'(r), 32'hFFFF_FFFF);
      end
      2: begin
        for (int r = CFG_X_LIMIT; r <= CFG_HEAD_TOL; r++) write_reg(3'(r), 32'h0);
        write_reg(CFG_NONE, $urandom);
      end
      3: begin
        write_reg(CFG_X_LIMIT, $urandom_range(1, 100));
        write_reg(CFG_Y_LIMIT, $urandom_range(1, 100));
        write_reg(CFG_TURN_LIMIT, $urandom_range(1, 100));
        write_reg(CFG_POS_TOL, 32'h0000_FFFF);
        write_reg(CFG_HEAD_TOL, {16'($urandom), 16'($urandom_range(1, 65535))});
      end
      default: begin
        // upper bits are junk on purpose; the block keeps only the register width
        write_reg(CFG_X_LIMIT, {1'($urandom), 31'($urandom_range(1, 300000))});
        write_reg(CFG_Y_LIMIT, {1'($urandom), 31'($urandom_range(1, 300000))});
        write_reg(CFG_TURN_LIMIT, {1'($urandom), 31'($urandom_range(1, 300000))});
        write_reg(CFG_POS_TOL, {16'($urandom), 16'($urandom_range(1, 20000))});
        write_reg(CFG_HEAD_TOL, {16'($urandom), 16'($urandom_range(1, 20000))});
      end
    endcase
  endtask

  function automatic logic signed [POS_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return 32'($urandom);
      1: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return 32'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic logic signed [YAW_W-1:0] rand_yaw();
    if ($urandom_range(99) < 85) return 19'(int'($urandom_range(0, 411774)) - 205887);
    return 19'($urandom);
  endfunction

  // mostly within twice the tolerance of c, so both sides of the bound show up
  function automatic logic signed [POS_W-1:0] near_coord(input logic signed [POS_W-1:0] c,
                                                         input longint t);
    if ($urandom_range(9) < 6)
      return c + 32'(int'($urandom_range(0, 32'(4 * t + 2))) - int'(2 * t + 1));
    return rand_coord();
  endfunction

  function automatic logic signed [YAW_W-1:0] near_yaw(input logic signed [YAW_W-1:0] c,
                                                       input longint t);
    if ($urandom_range(9) < 6)
      return c + 19'(int'($urandom_range(0, 32'(4 * t + 2))) - int'(2 * t + 1));
    return rand_yaw();
  endfunction

  // one goal followed by a few odometry updates and ticks; sometimes plain noise
  task automatic run_episode();
    logic signed [POS_W-1:0] gx, gy;
    logic signed [YAW_W-1:0] gyaw;
    int steps;
    if ($urandom_range(9) == 0) begin
      send_req(2'($urandom_range(3)), 32'($urandom), 32'($urandom), 19'($urandom), 1'b0, NO_CMD);
      return;
    end
    gx = rand_coord();
    gy = rand_coord();
    gyaw = rand_yaw();
    steps = $urandom_range(1, 6);
    send_req(REQ_GOAL, gx, gy, gyaw, 1'b0, NO_CMD);
    repeat (steps) begin
      if ($urandom_range(9) < 7)
        send_req(REQ_ODOM, near_coord(gx, pos_tol_q), near_coord(gy, pos_tol_q),
                 near_yaw(gyaw, head_tol_q), 1'b0, NO_CMD);
      send_req(REQ_TICK, 32'($urandom), 32'($urandom), 19'($urandom), 1'b0, NO_CMD);
      if ($urandom_range(9) < 3)
        send_req(REQ_TICK, 32'($urandom), 32'($urandom), 19'($urandom), 1'b0, NO_CMD);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic signed [VEL_W-1:0] want,
                                      input logic signed [VEL_W-1:0] got);
    if (got !== want) begin
      errors++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    vel_cmd_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cmd_q.size() == 0) begin
        errors++;
        $error("command with no request behind it: fwd %0d side %0d turn %0d arrived %0b",
               vel_forward_o, vel_sideways_o, vel_turn_o, arrived_o);
      end else begin
        want = cmd_q.pop_front();
        n_checked++;
        check_field("vel_forward", want.fwd, vel_forward_o);
        check_field("vel_sideways", want.side, vel_sideways_o);
        check_field("vel_turn", want.turn, vel_turn_o);
        check_field("arrived", 32'(want.arrived), 32'(arrived_o));
      end
    end
  end

  // watchdog: consecutive cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d commands pending",
                 idle_cycles, cmd_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case ((ph + ph / 4) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      if (ph > 0) load_settings(ph % 4);
      if (ph == 0) begin
        foreach (DIRECTED[r])
          send_req(DIRECTED[r].kind, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].yaw,
                   DIRECTED[r].known, DIRECTED[r].cmd);
        // long output hold-off against a far goal so the queue fills and input stalls
        hold_req = 1'b1;
        send_req(REQ_ODOM, 32'sd0, 32'sd0, 19'sd0, 1'b0, NO_CMD);
        send_req(REQ_GOAL, POS_MAX, POS_MIN, 19'sd0, 1'b0, NO_CMD);
        repeat (8) send_req(REQ_TICK, 32'sd0, 32'sd0, 19'sd0, 1'b0, NO_CMD);
      end
      while (n_items < (ph + 1) * PHASE_ITEMS) run_episode();
      drain_cmds();
    end

    $display("covered %0d requests in %0d phases, %0d register writes",
             n_items, N_PHASES, n_writes);
    $display("checked %0d commands: %0d turns, %0d translations, %0d arrivals",
             n_checked, n_turns, n_moves, n_arrivals);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
